FILE: sv/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg: shared definitions for the coordinate deque
// Request codes, fixed field widths and the per-item result info that
// travels from the control unit to the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

    // Default configuration.
    localparam int DEPTH_DEF       = 64;
    localparam int COORD_WIDTH_DEF = 16;

    // Fixed widths of the stream fields.
    localparam int REQ_W   = 3;
    localparam int POS_W   = 8;
    localparam int FIELD_W = 16;
    localparam int COUNT_W = 7;

    // Request codes carried in s_tuser.
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WRITE      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ       = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DROP_LAST  = 3'd5;

    // Coordinate returned by a read past the end.
    localparam logic signed [FIELD_W-1:0] MISS_COORD = -16'sd5;

    // Result information known at the time an item is accepted.
    typedef struct packed {
        logic               rd;
        logic               hit;
        logic               refused;
        logic [COUNT_W-1:0] count;
    } cdq_info_t;

endpackage

`default_nettype wire

FILE: sv/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire                      re,
    input  wire  [$clog2(DEPTH)-1:0] addr,
    input  wire  [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl: deque pointer and count control
// Holds the front pointer and entry count, decodes each request and issues
// the one RAM access, if any, that it needs.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl #(
    parameter int DEPTH       = cdq_pkg::DEPTH_DEF,
    parameter int COORD_WIDTH = cdq_pkg::COORD_WIDTH_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  accept,
    input  wire  [cdq_pkg::REQ_W-1:0]            req,
    input  wire  [cdq_pkg::POS_W-1:0]            pos,
    input  wire  signed [cdq_pkg::FIELD_W-1:0]   coord_x,
    input  wire  signed [cdq_pkg::FIELD_W-1:0]   coord_y,
    output logic                                 ram_we,
    output logic                                 ram_re,
    output logic [$clog2(DEPTH)-1:0]             ram_addr,
    output logic [2*COORD_WIDTH-1:0]             ram_wdata,
    output cdq_pkg::cdq_info_t                   info
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int PW   = (CNTW > cdq_pkg::POS_W) ? CNTW : cdq_pkg::POS_W;

    localparam logic [AW-1:0]   LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [AW:0]     DEPTH_W   = (AW + 1)'(DEPTH);
    localparam logic [CNTW-1:0] FULL_CNT  = CNTW'(DEPTH);

    logic [AW-1:0]   front_reg, front_next;
    logic [CNTW-1:0] count_reg, count_next;

    logic            full;
    logic            pos_in;
    logic [AW-1:0]   front_dec;
    logic [AW-1:0]   ring_idx;
    logic [AW:0]     ring_sum;
    logic [AW-1:0]   ring_addr;
    logic            is_push;

    assign full      = (count_reg == FULL_CNT);
    assign pos_in    = (PW'(pos) < PW'(count_reg));
    assign front_dec = (front_reg == '0) ? LAST_ADDR : front_reg - 1'b1;
    assign is_push   = (req == cdq_pkg::REQ_PUSH_FRONT) || (req == cdq_pkg::REQ_PUSH_BACK);

    // Push back addresses the slot just past the last entry; read and write
    // address the slot at the requested index.
    assign ring_idx  = (req == cdq_pkg::REQ_PUSH_BACK) ? AW'(count_reg) : AW'(pos);
    assign ring_sum  = {1'b0, front_reg} + {1'b0, ring_idx};
    assign ring_addr = (ring_sum >= DEPTH_W) ? AW'(ring_sum - DEPTH_W) : AW'(ring_sum);

    assign ram_addr  = (req == cdq_pkg::REQ_PUSH_FRONT) ? front_dec : ring_addr;
    assign ram_wdata = {COORD_WIDTH'(coord_y), COORD_WIDTH'(coord_x)};
    assign ram_we    = accept && ((is_push && !full) || ((req == cdq_pkg::REQ_WRITE) && pos_in));
    assign ram_re    = accept && (req == cdq_pkg::REQ_READ) && pos_in;

    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        unique case (req)
            cdq_pkg::REQ_CLEAR: begin
                front_next = '0;
                count_next = '0;
            end
            cdq_pkg::REQ_PUSH_FRONT: begin
                if (!full) begin
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            cdq_pkg::REQ_PUSH_BACK: begin
                if (!full) begin
                    count_next = count_reg + 1'b1;
                end
            end
            cdq_pkg::REQ_DROP_LAST: begin
                if (count_reg != '0) begin
                    count_next = count_reg - 1'b1;
                    if (count_reg == CNTW'(1)) begin
                        front_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        info.rd      = (req == cdq_pkg::REQ_READ);
        info.hit     = ((req == cdq_pkg::REQ_READ) || (req == cdq_pkg::REQ_WRITE)) && pos_in;
        info.refused = is_push && full;
        info.count   = cdq_pkg::COUNT_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
        end else if (accept) begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/coordinate_deque_indexed_unit.sv
// ----------------------------------------------------------------------------
// coordinate_deque_indexed_unit: bounded deque of coordinate pairs
// Ring buffer in one RAM with indexed read and write, push at either end,
// drop of the last entry and clear. One result item per request.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Contents
//  s_       in         s_tvalid/s_tready  request: code, index, x, y
//  m_       out        m_tvalid/m_tready  result: x, y, count, hit, refused
//
//  One request is accepted per cycle while s_tready is high; the result is registered.
//  Each request makes at most one RAM access, and a read's data comes from
//  the registered RAM output in the following cycle.
//  Reset (aresetn low at a clock edge) empties the deque; RAM contents stay.
//  A stalled result holds the pipeline stage behind it and then s_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module coordinate_deque_indexed_unit #(
    parameter int DEPTH       = cdq_pkg::DEPTH_DEF,
    parameter int COORD_WIDTH = cdq_pkg::COORD_WIDTH_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // position[7:0], coord_x[23:8], coord_y[39:24]
    input  wire  [2:0]  s_tuser,   // req_type[2:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // read_x[15:0], read_y[31:16], entry_count[38:32], 0
    output logic [1:0]  m_tuser    // hit[0], refused[1]
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = cdq_pkg::FIELD_W;

    logic                       s_accept;
    logic                       s1_advance;
    logic                       ram_we;
    logic                       ram_re;
    logic [AW-1:0]              ram_addr;
    logic [2*COORD_WIDTH-1:0]   ram_wdata;
    logic [2*COORD_WIDTH-1:0]   ram_rdata;
    cdq_pkg::cdq_info_t         info;

    logic                       s1_valid_reg, s1_valid_next;
    cdq_pkg::cdq_info_t         s1_info_reg;

    logic                       m_valid_reg, m_valid_next;
    logic signed [FW-1:0]       m_x_reg, m_x_next;
    logic signed [FW-1:0]       m_y_reg, m_y_next;
    logic                       m_hit_reg;
    logic                       m_ref_reg;
    logic [cdq_pkg::COUNT_W-1:0] m_cnt_reg;

    logic signed [COORD_WIDTH-1:0] rd_x;
    logic signed [COORD_WIDTH-1:0] rd_y;

    assign s1_advance = !m_valid_reg || m_tready;
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_accept   = s_tvalid && s_tready;

    cdq_ctrl #(
        .DEPTH       (DEPTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_accept),
        .req       (s_tuser),
        .pos       (s_tdata[7:0]),
        .coord_x   (s_tdata[23:8]),
        .coord_y   (s_tdata[39:24]),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .info      (info)
    );

    cdq_ram #(
        .WIDTH (2 * COORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // The RAM output only changes on a read, and no new item enters while
    // stage one waits, so the read data stays valid for as long as needed.
    assign rd_x = ram_rdata[COORD_WIDTH-1:0];
    assign rd_y = ram_rdata[2*COORD_WIDTH-1:COORD_WIDTH];

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_advance) begin
            m_valid_next = s1_valid_reg;
        end
    end

    always_comb begin
        priority if (s1_info_reg.rd && s1_info_reg.hit) begin
            m_x_next = FW'(rd_x);
            m_y_next = FW'(rd_y);
        end else if (s1_info_reg.rd) begin
            m_x_next = cdq_pkg::MISS_COORD;
            m_y_next = cdq_pkg::MISS_COORD;
        end else begin
            m_x_next = '0;
            m_y_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_info_reg <= info;
        end
        if (s1_advance && s1_valid_reg) begin
            m_x_reg   <= m_x_next;
            m_y_reg   <= m_y_next;
            m_hit_reg <= s1_info_reg.hit;
            m_ref_reg <= s1_info_reg.refused;
            m_cnt_reg <= s1_info_reg.count;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_cnt_reg, m_y_reg, m_x_reg};
    assign m_tuser  = {m_ref_reg, m_hit_reg};

`ifndef ASSERT_OFF
    // An accepted item always lands in stage one.
    a_accept_to_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> s1_valid_reg)
        else $error("accepted item did not reach stage one");

    // Stage one must hold its item while the result register is stalled.
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_tready) |=>
            (s1_valid_reg && $stable(s1_info_reg)))
        else $error("stage one changed under a stalled result");

    // A refused push neither hits nor returns coordinates.
    a_refused_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (!m_tuser[0] && (m_tdata[31:0] == 32'd0)))
        else $error("refused push carries hit or coordinate data");
`endif

endmodule

`default_nettype wire

FILE: sim/coordinate_deque_indexed_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coordinate_deque_indexed_unit_checker: result checker for the deque
// Watches both stream channels. Each accepted request item updates a private
// copy of the ring buffer and queues the result it should give. Each accepted
// result item is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------

module coordinate_deque_indexed_unit_checker #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [39:0] s_tdata,   // position[7:0], coord_x[23:8], coord_y[39:24]
    input  wire  [2:0]  s_tuser,   // req_type[2:0]
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [39:0] m_tdata,   // read_x[15:0], read_y[31:16], entry_count[38:32], 0
    input  wire  [1:0]  m_tuser,   // hit[0], refused[1]
    output int          mismatch_count,
    output int          results_owed
);
    import cdq_pkg::*;

    typedef struct packed {
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic                      hit;
        logic                      refused;
        logic [COUNT_W-1:0]        count;
    } deque_result_t;

    logic [2*FIELD_W-1:0] pair_ram [DEPTH];
    int unsigned          front_addr = 0;
    int unsigned          fill = 0;
    deque_result_t        expected_results [$];
    int                   err_tally = 0;
    int                   owed = 0;

    assign mismatch_count = err_tally;
    assign results_owed   = owed;

    // Applies one request to the model deque and returns the result it gives.
    task automatic apply_request(input logic [REQ_W-1:0] code, input logic [POS_W-1:0] idx,
                                 input logic [FIELD_W-1:0] cx, input logic [FIELD_W-1:0] cy,
                                 output deque_result_t res);
        res = '0;
        case (code)
            REQ_CLEAR: begin
                fill = 0;
                front_addr = 0;
            end
            REQ_PUSH_FRONT: begin
                if (fill >= DEPTH) begin
                    res.refused = 1'b1;
                end else begin
                    front_addr = (front_addr == 0) ? DEPTH - 1 : front_addr - 1;
                    pair_ram[front_addr] = {cy, cx};
                    fill++;
                end
            end
            REQ_PUSH_BACK: begin
                if (fill >= DEPTH) begin
                    res.refused = 1'b1;
                end else begin
                    pair_ram[(front_addr + fill) % DEPTH] = {cy, cx};
                    fill++;
                end
            end
            REQ_WRITE: begin
                if (idx < fill) begin
                    pair_ram[(front_addr + idx) % DEPTH] = {cy, cx};
                    res.hit = 1'b1;
                end
            end
            REQ_READ: begin
                if (idx < fill) begin
                    {res.y, res.x} = pair_ram[(front_addr + idx) % DEPTH];
                    res.hit = 1'b1;
                end else begin
                    res.x = MISS_COORD;
                    res.y = MISS_COORD;
                end
            end
            REQ_DROP_LAST: begin
                if (fill > 0) begin
                    fill--;
                    // An emptied deque restarts at address zero.
                    if (fill == 0)
                        front_addr = 0;
                end
            end
            default: ;
        endcase
        res.count = fill[COUNT_W-1:0];
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_tally++;
        end
    endtask

    always @(posedge aclk) begin
        deque_result_t want;
        deque_result_t got;
        if (!aresetn) begin
            fill = 0;
            front_addr = 0;
            expected_results.delete();
        end else begin
            // The request is queued first so that no latency is assumed.
            if (s_tvalid && s_tready) begin
                apply_request(s_tuser, s_tdata[7:0], s_tdata[23:8], s_tdata[39:24], want);
                expected_results.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.x       = m_tdata[15:0];
                got.y       = m_tdata[31:16];
                got.count   = m_tdata[38:32];
                got.hit     = m_tuser[0];
                got.refused = m_tuser[1];
                if (expected_results.size() == 0) begin
                    $error("result item with no request outstanding");
                    err_tally++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_x", want.x, got.x);
                    check_field("read_y", want.y, got.y);
                    check_field("hit", want.hit, got.hit);
                    check_field("refused", want.refused, got.refused);
                    check_field("entry_count", want.count, got.count);
                end
            end
        end
        owed = expected_results.size();
    end

endmodule

FILE: sim/coordinate_deque_indexed_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coordinate_deque_indexed_unit_tb: testbench for the coordinate deque
// Sends a directed run of edge cases, then random requests in blocks that
// fill, mix and drain the deque, with random gaps and result stalls. The
// checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------

module coordinate_deque_indexed_unit_tb;
    import cdq_pkg::*;

    // Request codes the block does not use.
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 1450;
    localparam int BLOCK_ITEMS  = 100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 16;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [39:0]  s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tready = 1'b0;
    wire          s_tready;
    wire          m_tvalid;
    wire  [39:0]  m_tdata;
    wire  [1:0]   m_tuser;

    bit           gaps_on = 1'b1;
    int           cycle_count = 0;
    int           mismatch_count;
    int           results_owed;

    always #1 aclk = ~aclk;

    coordinate_deque_indexed_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    coordinate_deque_indexed_unit_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= !gaps_on || ($urandom_range(0, 99) >= 16);
    end

    // Presents one request item and returns once it has been accepted.
    task automatic send_request(input logic [REQ_W-1:0] code, input logic [POS_W-1:0] idx,
                                input logic [FIELD_W-1:0] cx, input logic [FIELD_W-1:0] cy);
        @(negedge aclk);
        while (gaps_on && $urandom_range(0, 99) < 16) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= code;
        s_tdata  <= {cy, cx, idx};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Percentages steer the deque toward full, empty or a steady mix.
    task automatic random_request(input int push_pct, input int drop_pct, input int clear_pct);
        int               roll;
        logic [REQ_W-1:0] code;
        logic [POS_W-1:0] idx;
        roll = $urandom_range(0, 99);
        if (roll < clear_pct)
            code = REQ_CLEAR;
        else if (roll < clear_pct + 2)
            code = $urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
        else if (roll < clear_pct + 2 + push_pct)
            code = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        else if (roll < clear_pct + 2 + push_pct + drop_pct)
            code = REQ_DROP_LAST;
        else
            code = $urandom_range(0, 1) ? REQ_READ : REQ_WRITE;
        // Most indexes land around the occupied range so both hits and misses occur.
        idx = ($urandom_range(0, 99) < 80) ? POS_W'($urandom_range(0, 70))
                                           : POS_W'($urandom_range(0, 255));
        send_request(code, idx, FIELD_W'($urandom()), FIELD_W'($urandom()));
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        send_request(REQ_READ,       8'd0,   16'h0000, 16'h0000);
        send_request(REQ_DROP_LAST,  8'd0,   16'h0000, 16'h0000);
        send_request(REQ_PUSH_BACK,  8'd0,   16'h7FFF, 16'h8000);
        send_request(REQ_PUSH_FRONT, 8'd0,   16'h8000, 16'h7FFF);
        send_request(REQ_READ,       8'd0,   16'h0000, 16'h0000);
        send_request(REQ_READ,       8'd1,   16'h0000, 16'h0000);
        send_request(REQ_READ,       8'd2,   16'h0000, 16'h0000);
        send_request(REQ_WRITE,      8'd1,   16'hFFFF, 16'h0000);
        send_request(REQ_WRITE,      8'd2,   16'h1111, 16'h2222);
        send_request(REQ_WRITE,      8'hFF,  16'h3333, 16'h4444);
        send_request(REQ_READ,       8'hFF,  16'hFFFF, 16'hFFFF);
        send_request(REQ_READ,       8'd1,   16'h0000, 16'h0000);
        send_request(REQ_DROP_LAST,  8'd0,   16'h0000, 16'h0000);
        send_request(REQ_READ,       8'd0,   16'h0000, 16'h0000);
        // Dropping the only entry empties the deque.
        send_request(REQ_DROP_LAST,  8'd0,   16'h0000, 16'h0000);
        send_request(REQ_READ,       8'd0,   16'h0000, 16'h0000);
        send_request(REQ_SPARE_LO,   8'hFF,  16'hFFFF, 16'hFFFF);
        send_request(REQ_SPARE_HI,   8'd0,   16'h8000, 16'h7FFF);
        send_request(REQ_PUSH_FRONT, 8'd0,   16'h1234, 16'h5678);
        send_request(REQ_PUSH_BACK,  8'd0,   16'h0000, 16'hFFFF);
        send_request(REQ_CLEAR,      8'hFF,  16'hFFFF, 16'hFFFF);
        send_request(REQ_READ,       8'd0,   16'h0000, 16'h0000);
        send_request(REQ_PUSH_BACK,  8'd0,   16'h7FFF, 16'h7FFF);
        send_request(REQ_READ,       8'd0,   16'h0000, 16'h0000);
        send_request(REQ_DROP_LAST,  8'd0,   16'h0000, 16'h0000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // One stretch runs with neither side idling.
            gaps_on = !(n >= 600 && n < 900);
            case ((n / BLOCK_ITEMS) % 4)
                0: random_request(80, 5, 0);
                1: random_request(25, 20, 1);
                2: random_request(5, 60, 0);
                default: random_request(30, 25, 1);
            endcase
        end
        gaps_on = 1'b1;

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (results_owed != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
